// ===== rtl/unique_id_set_swap_remove_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unique id set unit
// Each macro builds a labeled concurrent assertion, or nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_SET_SWAP_REMOVE_UNIT_DEFINES_SVH
`define UNIQUE_ID_SET_SWAP_REMOVE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define UISR_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define UISR_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define UISR_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define UISR_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/uisr_pkg.sv =====
// ----------------------------------------------------------------------------
// uisr_pkg
// Types, codes and defaults shared by the unique id set unit.
// ----------------------------------------------------------------------------
package uisr_pkg;

    localparam int          UISR_DEPTH      = 64;
    localparam logic [31:0] UISR_INVALID_ID = 32'd0;
    localparam logic [6:0]  UISR_CAP_RESET  = 7'd64;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] id;
    } op_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] count_after;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic       op_load;
        logic       scan_start;
        logic       scan_step;
        logic       append;
        logic       move_rd;
        logic       move_wr;
        logic       clear;
        logic       out_load;
        logic [2:0] status;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       is_invalid;
        logic       is_full;
        logic       hit;
        logic       exhausted;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== rtl/uisr_ctrl.sv =====
// ----------------------------------------------------------------------------
// uisr_ctrl
// Sequencer for add, remove and clear: check, scan, update, report.
// ----------------------------------------------------------------------------
module uisr_ctrl
    import uisr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_APPEND,
        S_MOVE_RD,
        S_MOVE_WR,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.op_load = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next  = S_FINISH;
                status_next = ST_DONE;
                unique case (stat.action)
                    ACT_ADD:
                    begin
                        if (stat.is_invalid)
                            status_next = ST_INVALID;
                        else if (stat.is_full)
                            status_next = ST_FULL;
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.is_invalid)
                            status_next = ST_INVALID;
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    ACT_CLEAR:
                        cmd.clear = 1'b1;
                    default:
                        status_next = ST_DONE;
                endcase
            end
            S_SCAN:
            begin
                // Hold the matching slot once found
                cmd.scan_step = !stat.hit;
                if (stat.hit)
                begin
                    if (stat.action == ACT_ADD)
                    begin
                        status_next = ST_PRESENT;
                        state_next  = S_FINISH;
                    end
                    else
                        state_next = S_MOVE_RD;
                end
                else if (stat.exhausted)
                begin
                    if (stat.action == ACT_ADD)
                        state_next = S_APPEND;
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.append  = 1'b1;
                status_next = ST_DONE;
                state_next  = S_FINISH;
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                status_next = ST_DONE;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign op_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/uisr_dpath.sv =====
// ----------------------------------------------------------------------------
// uisr_dpath
// Entry table, count, capacity register, scan pointer and result register.
// ----------------------------------------------------------------------------
`include "unique_id_set_swap_remove_unit_defines.svh"

module uisr_dpath
    import uisr_pkg::*;
#(
    parameter int          DEPTH      = UISR_DEPTH,
    parameter logic [31:0] INVALID_ID = UISR_INVALID_ID
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  logic       cap_we,
    input  logic [6:0] cap_wdata,
    input  logic       res_stall,
    output logic       res_valid,
    output res_t       res,
    input  ctl_cmd_t   cmd,
    output dp_stat_t   stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [31:0]      mem [DEPTH];

    op_t              op_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [6:0]       cap_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [31:0]      rd_data_reg;
    logic             res_valid_reg;
    res_t             res_reg;

    logic             can_issue;
    logic             issue_now;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      wr_data;
    logic [CNT_W-1:0] last_cnt;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] depth_c;
    logic [CMP_W-1:0] eff_cap;

    assign can_issue = (issue_reg < count_reg);
    assign issue_now = cmd.scan_step && can_issue;
    assign last_cnt  = count_reg - CNT_W'(1);

    assign mem_we  = cmd.append || cmd.move_wr;
    assign mem_re  = cmd.move_rd || issue_now;
    assign wr_addr = cmd.append ? count_reg[IDX_W-1:0] : cmp_idx_reg;
    assign wr_data = cmd.append ? op_reg.id : rd_data_reg;
    assign rd_addr = cmd.move_rd ? last_cnt[IDX_W-1:0] : issue_reg[IDX_W-1:0];

    // Capacity above the table size is clipped to the table size
    assign cap_ext = CMP_W'(cap_reg);
    assign depth_c = CMP_W'(DEPTH);
    assign eff_cap = (cap_ext < depth_c) ? cap_ext : depth_c;

    always_comb
    begin
        stat.action     = op_reg.action;
        stat.is_invalid = (op_reg.id == INVALID_ID);
        stat.is_full    = (CMP_W'(count_reg) >= eff_cap);
        stat.hit        = pend_reg && (rd_data_reg == op_reg.id);
        stat.exhausted  = !pend_reg && !can_issue;
        stat.out_free   = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        priority if (cmd.clear)
            count_next = '0;
        else if (cmd.append)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.move_wr)
            count_next = last_cnt;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
            op_reg <= op;
        if (issue_now)
            cmp_idx_reg <= issue_reg[IDX_W-1:0];
        if (cmd.out_load)
        begin
            res_reg.status      <= cmd.status;
            res_reg.count_after <= 7'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= UISR_CAP_RESET;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cap_we)
                cap_reg <= cap_wdata;
            if (cmd.scan_start)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= can_issue;
                if (can_issue)
                    issue_reg <= issue_reg + CNT_W'(1);
            end
            if (cmd.out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `UISR_ASSERT_NXT(a_append_grows, clk, rst_n, cmd.append, count_reg == $past(count_reg) + CNT_W'(1), "append did not grow the count")
    `UISR_ASSERT_NXT(a_remove_shrinks, clk, rst_n, cmd.move_wr, count_reg == $past(count_reg) - CNT_W'(1), "remove did not shrink the count")
    `UISR_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !res_valid_reg || !res_stall, "result overwritten while stalled")
    `UISR_ASSERT_IMP(a_append_room, clk, rst_n, cmd.append, CMP_W'(count_reg) < eff_cap, "append beyond capacity")

endmodule

// ===== rtl/unique_id_set_swap_remove_unit.sv =====
// ----------------------------------------------------------------------------
// unique_id_set_swap_remove_unit
// Set of distinct nonzero ids in a packed table with swap-with-last removal.
//
//   Channel  Direction  Handshake           Payload
//   op       in         op_valid/op_stall   op_t  {action, id}
//   res      out        res_valid/res_stall res_t {status, count_after}
//   cap      in         cap_we              cap_wdata (capacity_in_use)
//
// Add and remove scan the table one entry a cycle through a single read port
// and stop early on a match; an add then appends, a remove reads the last entry
// and writes it into the freed slot. Clear and rejected ops skip the scan.
// A new op is taken once the previous one is handed to the result register.
// Reset clears count and sets capacity to 64; the table needs no clearing.
// A stalled result holds; the sequencer waits in its last step until free.
// ----------------------------------------------------------------------------
module unique_id_set_swap_remove_unit
    import uisr_pkg::*;
#(
    parameter int          DEPTH      = UISR_DEPTH,
    parameter logic [31:0] INVALID_ID = UISR_INVALID_ID
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_stall,
    input  op_t        op,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res,
    input  logic       cap_we,
    input  logic [6:0] cap_wdata
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    uisr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    uisr_dpath #(
        .DEPTH      (DEPTH),
        .INVALID_ID (INVALID_ID)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
